>>> hdl/cpp_pkg.sv
package cpp_pkg;

    localparam int NUM_VERBS     = 6;
    localparam int VERB_CHARS    = 9;
    localparam int MAX_DIGITS    = 10;

    localparam logic [3:0]  TOKEN_LEN_SAT = 4'd10;
    localparam logic [3:0]  DIGIT_SAT     = 4'd11;
    localparam logic [16:0] COUNT_SAT     = 17'h1FFFF;

    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_PRINT_LO  = 8'h21;
    localparam logic [7:0] CHAR_PRINT_HI  = 8'h7E;
    localparam logic [7:0] CHAR_DIGIT_LO  = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_HI  = 8'h39;

    typedef logic [2:0] verb_t;
    localparam verb_t VERB_UNKNOWN   = 3'd0;
    localparam verb_t VERB_STATUS    = 3'd1;
    localparam verb_t VERB_LEASE     = 3'd2;
    localparam verb_t VERB_HEARTBEAT = 3'd3;
    localparam verb_t VERB_ARM       = 3'd4;
    localparam verb_t VERB_DISARM    = 3'd5;
    localparam verb_t VERB_RELEASE   = 3'd6;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_MIN_LEASE   = 2'd0;
    localparam cfg_index_t CFG_MAX_LEASE   = 2'd1;
    localparam cfg_index_t CFG_MAX_PAYLOAD = 2'd2;

    // verb text, space padded to VERB_CHARS
    localparam logic [8*VERB_CHARS-1:0] VERB_TEXT [NUM_VERBS] = '{
        "STATUS   ", "LEASE    ", "HEARTBEAT", "ARM      ", "DISARM   ", "RELEASE  "
    };
    localparam logic [3:0] VERB_LEN [NUM_VERBS] = '{
        4'd6, 4'd5, 4'd9, 4'd3, 4'd6, 4'd7
    };

    typedef struct packed {
        logic [31:0] min_lease_ms;
        logic [31:0] max_lease_ms;
        logic [15:0] max_payload_len;
    } cpp_cfg_t;

    // parse state, also the snapshot handed to the result stage
    typedef struct packed {
        logic [16:0] byte_count;
        logic        in_second_token;
        logic        first_token_bad;
        logic [5:0]  verb_candidates;
        logic [3:0]  first_token_length;
        logic        second_token_bad;
        logic [3:0]  digit_count;
        logic [31:0] lease_accumulator;
    } cpp_state_t;

    localparam cpp_state_t STATE_CLEAR = '{
        byte_count:         '0,
        in_second_token:    1'b0,
        first_token_bad:    1'b0,
        verb_candidates:    6'h3F,
        first_token_length: '0,
        second_token_bad:   1'b0,
        digit_count:        '0,
        lease_accumulator:  '0
    };

    function automatic logic [7:0] verb_char(input int idx, input logic [3:0] pos);
        int p;
        p = int'(pos);
        if (p < VERB_CHARS)
            return VERB_TEXT[idx][8*(VERB_CHARS-1-p) +: 8];
        else
            return 8'h00;
    endfunction

endpackage

>>> hdl/cpp_if.sv
interface cpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface cpp_result_if;
    logic                valid;
    logic                ready;
    cpp_pkg::verb_t      verb;
    logic                well_formed;
    logic                lease_given;
    logic [31:0]         lease_ms;

    modport source (output valid, output verb, output well_formed, output lease_given,
                    output lease_ms, input ready);
    modport sink   (input valid, input verb, input well_formed, input lease_given,
                    input lease_ms, output ready);
endinterface

interface cpp_cfg_if;
    logic                  valid;
    logic                  ready;
    cpp_pkg::cfg_index_t   index;
    logic [31:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/cpp_cfg.sv
module cpp_cfg (
    input  logic              clk,
    input  logic              rst_n,
    cpp_cfg_if.sink           cfg,
    output cpp_pkg::cpp_cfg_t regs
);
    import cpp_pkg::*;

    cpp_cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.min_lease_ms    <= 32'd1000;
            regs_reg.max_lease_ms    <= 32'd300000;
            regs_reg.max_payload_len <= 16'd4096;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MIN_LEASE:   regs_reg.min_lease_ms    <= cfg.data;
                CFG_MAX_LEASE:   regs_reg.max_lease_ms    <= cfg.data;
                CFG_MAX_PAYLOAD: regs_reg.max_payload_len <= cfg.data[15:0];
                default:         ;
            endcase
        end
    end

endmodule

>>> hdl/cpp_scan.sv
module cpp_scan (
    input  logic                clk,
    input  logic                rst_n,
    cpp_byte_if.sink            byte_in,
    input  logic                load_ok,
    output logic                snap_valid,
    output cpp_pkg::cpp_state_t snap
);
    import cpp_pkg::*;

    cpp_state_t state_reg, state_next;
    cpp_state_t snap_reg;
    logic       snap_valid_reg;
    logic       accept;
    logic [7:0] b;
    logic [35:0] acc_times_ten;
    logic [35:0] acc_sum;
    logic       is_digit;

    assign byte_in.ready = !snap_valid_reg || load_ok;
    assign accept        = byte_in.valid && byte_in.ready;
    assign snap_valid    = snap_valid_reg;
    assign snap          = snap_reg;
    assign b             = byte_in.data_byte;

    assign is_digit      = (b >= CHAR_DIGIT_LO) && (b <= CHAR_DIGIT_HI);
    assign acc_times_ten = ({4'b0, state_reg.lease_accumulator} << 3)
                         + ({4'b0, state_reg.lease_accumulator} << 1);
    assign acc_sum       = acc_times_ten + {32'b0, b[3:0]};

    always_comb
    begin
        state_next = state_reg;
        if (state_reg.byte_count != COUNT_SAT)
            state_next.byte_count = state_reg.byte_count + 17'd1;

        if (state_reg.in_second_token)
        begin
            if (b == CHAR_SPACE)
                state_next.second_token_bad = 1'b1;
            else
            begin
                if (!is_digit)
                    state_next.second_token_bad = 1'b1;
                else
                begin
                    if (acc_sum[35:32] != 4'd0)
                        state_next.second_token_bad = 1'b1;
                    state_next.lease_accumulator = acc_sum[31:0];
                end
                if (state_reg.digit_count != DIGIT_SAT)
                    state_next.digit_count = state_reg.digit_count + 4'd1;
            end
        end
        else if (b == CHAR_SPACE)
        begin
            if (state_reg.first_token_length == 4'd0)
                state_next.first_token_bad = 1'b1;
            state_next.in_second_token = 1'b1;
        end
        else
        begin
            if (b < CHAR_PRINT_LO || b > CHAR_PRINT_HI)
                state_next.first_token_bad = 1'b1;
            for (int i = 0; i < NUM_VERBS; i++)
            begin
                if (!(state_reg.first_token_length < VERB_LEN[i]
                      && verb_char(i, state_reg.first_token_length) == b))
                    state_next.verb_candidates[i] = 1'b0;
            end
            if (state_reg.first_token_length != TOKEN_LEN_SAT)
                state_next.first_token_length = state_reg.first_token_length + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= STATE_CLEAR;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (snap_valid_reg && load_ok)
                snap_valid_reg <= 1'b0;
            if (accept)
            begin
                if (byte_in.last)
                begin
                    state_reg      <= STATE_CLEAR;
                    snap_valid_reg <= 1'b1;
                end
                else
                    state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && byte_in.last)
            snap_reg <= state_next;
    end

endmodule

>>> hdl/cpp_result.sv
module cpp_result (
    input  logic                clk,
    input  logic                rst_n,
    input  cpp_pkg::cpp_cfg_t   regs,
    input  logic                snap_valid,
    input  cpp_pkg::cpp_state_t snap,
    output logic                load_ok,
    cpp_result_if.source        result_out
);
    import cpp_pkg::*;

    logic        valid_reg;
    verb_t       verb_reg, verb_next;
    logic        wf_reg, wf_next;
    logic        given_reg, given_next;
    logic [31:0] ms_reg, ms_next;
    verb_t       matched;
    logic        length_ok;
    logic        value_verb;
    logic        digits_ok;

    assign load_ok = !valid_reg || result_out.ready;

    assign result_out.valid       = valid_reg;
    assign result_out.verb        = verb_reg;
    assign result_out.well_formed = wf_reg;
    assign result_out.lease_given = given_reg;
    assign result_out.lease_ms    = ms_reg;

    // lowest verb index wins
    always_comb
    begin
        matched = VERB_UNKNOWN;
        for (int i = NUM_VERBS - 1; i >= 0; i--)
        begin
            if (snap.verb_candidates[i] && snap.first_token_length == VERB_LEN[i])
                matched = 3'(i + 1);
        end
    end

    assign length_ok  = snap.byte_count <= {1'b0, regs.max_payload_len};
    assign value_verb = (matched == VERB_LEASE) || (matched == VERB_HEARTBEAT)
                     || (matched == VERB_ARM);
    assign digits_ok  = (snap.digit_count != 4'd0)
                     && (snap.digit_count <= 4'(MAX_DIGITS));

    always_comb
    begin
        verb_next  = VERB_UNKNOWN;
        wf_next    = 1'b0;
        given_next = 1'b0;
        ms_next    = 32'd0;
        if (length_ok && !snap.first_token_bad)
        begin
            if (!snap.in_second_token)
            begin
                verb_next = matched;
                wf_next   = 1'b1;
            end
            else if (value_verb && !snap.second_token_bad && digits_ok)
            begin
                verb_next  = matched;
                wf_next    = 1'b1;
                given_next = 1'b1;
                // min takes precedence when the bounds are inverted
                if (snap.lease_accumulator < regs.min_lease_ms)
                    ms_next = regs.min_lease_ms;
                else if (snap.lease_accumulator > regs.max_lease_ms)
                    ms_next = regs.max_lease_ms;
                else
                    ms_next = snap.lease_accumulator;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load_ok)
            valid_reg <= snap_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && snap_valid)
        begin
            verb_reg  <= verb_next;
            wf_reg    <= wf_next;
            given_reg <= given_next;
            ms_reg    <= ms_next;
        end
    end

    a_bad_is_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !wf_reg |-> verb_reg == VERB_UNKNOWN)
        else $error("malformed result carries a verb");

    a_given_wf: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && given_reg |-> wf_reg)
        else $error("lease given on malformed payload");

    a_no_lease_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !given_reg |-> ms_reg == 32'd0)
        else $error("lease_ms nonzero without lease");

    a_given_verb: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && given_reg |-> verb_reg == VERB_LEASE || verb_reg == VERB_HEARTBEAT
                                   || verb_reg == VERB_ARM)
        else $error("lease given for verb without value");

    a_load_order: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid && load_ok |=> valid_reg)
        else $error("snapshot lost on load");

endmodule

>>> hdl/command_payload_parser.sv
// The accepted beat with last loads the snapshot register; the result beat then comes from the output register.
// Throughput: one byte per cycle while the byte channel is not stalled, including back-to-back payloads; a one-deep
// snapshot register sits between the byte scanner and the output register.
// Backpressure on the result channel stalls the byte channel once both fill.
// Reset (rst_n, async, active low) clears parse state, drops pending results and
// loads min_lease_ms 1000, max_lease_ms 300000, max_payload_len 4096.
module command_payload_parser (
    input  logic         clk,
    input  logic         rst_n,
    cpp_byte_if.sink     byte_in,
    cpp_result_if.source result_out,
    cpp_cfg_if.sink      cfg
);
    import cpp_pkg::*;

    cpp_cfg_t   regs;
    cpp_state_t snap;
    logic       snap_valid;
    logic       load_ok;

    cpp_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    cpp_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .load_ok    (load_ok),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    cpp_result u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .regs       (regs),
        .snap_valid (snap_valid),
        .snap       (snap),
        .load_ok    (load_ok),
        .result_out (result_out)
    );

endmodule

>>> tb/command_payload_parser_tb.sv
`timescale 1ns / 1ps

module command_payload_parser_tb;
    import cpp_pkg::*;

    localparam cfg_index_t CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_beat_t;

    typedef struct packed {
        verb_t       verb;
        logic        well_formed;
        logic        lease_given;
        logic [31:0] lease_ms;
    } parse_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cpp_byte_if   byte_in ();
    cpp_result_if result_out ();
    cpp_cfg_if    cfg ();

    command_payload_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .result_out (result_out),
        .cfg        (cfg)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    string verb_words [6] = '{"STATUS", "LEASE", "HEARTBEAT", "ARM", "DISARM", "RELEASE"};
    verb_t verb_codes [6] = '{VERB_STATUS, VERB_LEASE, VERB_HEARTBEAT, VERB_ARM,
                              VERB_DISARM, VERB_RELEASE};

    // shadow configuration
    logic [31:0] lease_floor;
    logic [31:0] lease_ceiling;
    logic [15:0] payload_limit;

    // shadow scanner state
    logic [16:0] seen_bytes;
    logic        past_space;
    logic        verb_bad;
    logic [5:0]  verb_hits;
    logic [3:0]  verb_chars;
    logic        arg_bad;
    logic [3:0]  digits_seen;
    logic [31:0] lease_acc;

    byte_beat_t    tx_queue [$];
    logic [7:0]    payload [$];
    parse_result_t expected_results [$];

    int  mismatches = 0;
    int  sender_idle_pct = 0;
    int  receiver_idle_pct = 0;
    logic rx_hold = 1'b0;
    event hold_kick;

    function automatic void clear_scan();
        seen_bytes  = '0;
        past_space  = 1'b0;
        verb_bad    = 1'b0;
        verb_hits   = 6'h3F;
        verb_chars  = '0;
        arg_bad     = 1'b0;
        digits_seen = '0;
        lease_acc   = '0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic last);
        logic [35:0]   wide;
        parse_result_t res;
        verb_t         v;
        logic          found;
        if (~&seen_bytes)
            seen_bytes++;
        if (past_space) begin
            if (b == CHAR_SPACE) begin
                arg_bad = 1'b1;
            end else begin
                if (b < CHAR_DIGIT_LO || b > CHAR_DIGIT_HI) begin
                    arg_bad = 1'b1;
                end else begin
                    wide = lease_acc * 36'd10 + 36'(b - CHAR_DIGIT_LO);
                    if (wide[35:32] != 4'd0)
                        arg_bad = 1'b1;
                    lease_acc = wide[31:0];
                end
                if (digits_seen < 4'd11)
                    digits_seen++;
            end
        end else if (b == CHAR_SPACE) begin
            if (verb_chars == 4'd0)
                verb_bad = 1'b1;
            past_space = 1'b1;
        end else begin
            if (b < CHAR_PRINT_LO || b > CHAR_PRINT_HI)
                verb_bad = 1'b1;
            for (int i = 0; i < 6; i++)
                if (!(verb_chars < verb_words[i].len() && 8'(verb_words[i][verb_chars]) == b))
                    verb_hits[i] = 1'b0;
            if (verb_chars < 4'd10)
                verb_chars++;
        end
        if (last) begin
            res = '0;
            if (seen_bytes <= {1'b0, payload_limit} && !verb_bad) begin
                v = VERB_UNKNOWN;
                found = 1'b0;
                for (int i = 0; i < 6; i++)
                    if (!found && verb_hits[i] && verb_chars == verb_words[i].len()) begin
                        v = verb_codes[i];
                        found = 1'b1;
                    end
                if (!past_space) begin
                    res.verb = v;
                    res.well_formed = 1'b1;
                end else if ((v == VERB_LEASE || v == VERB_HEARTBEAT || v == VERB_ARM) &&
                             !arg_bad && digits_seen >= 4'd1 && digits_seen <= 4'd10) begin
                    res.verb = v;
                    res.well_formed = 1'b1;
                    res.lease_given = 1'b1;
                    if (lease_acc < lease_floor)
                        res.lease_ms = lease_floor;
                    else if (lease_acc > lease_ceiling)
                        res.lease_ms = lease_ceiling;
                    else
                        res.lease_ms = lease_acc;
                end
            end
            expected_results.push_back(res);
            clear_scan();
        end
    endfunction

    // byte driver; predicts on every accepted beat
    always @(posedge clk)
    begin
        byte_beat_t beat;
        if (rst_n) begin
            if (byte_in.valid && byte_in.ready)
                parse_byte(byte_in.data_byte, byte_in.last);
            if (!byte_in.valid || byte_in.ready) begin
                if (tx_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    beat = tx_queue.pop_front();
                    byte_in.valid     <= 1'b1;
                    byte_in.data_byte <= beat.data;
                    byte_in.last      <= beat.last;
                end else begin
                    byte_in.valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // result monitor
    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n) begin
            if (result_out.valid && result_out.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got verb=%0d wf=%0b lg=%0b ms=%0d",
                             $time, result_out.verb, result_out.well_formed,
                             result_out.lease_given, result_out.lease_ms);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("verb", 32'(want.verb), 32'(result_out.verb));
                    check_field("well_formed", 32'(want.well_formed), 32'(result_out.well_formed));
                    check_field("lease_given", 32'(want.lease_given), 32'(result_out.lease_given));
                    check_field("lease_ms", want.lease_ms, result_out.lease_ms);
                end
            end
            result_out.ready <= !rx_hold && ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // long receiver stall so the block backs up into the byte channel
    always
    begin
        @(hold_kick);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #(64'd10_000_000);
        $display("FAIL");
        $finish;
    end

    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            CFG_MIN_LEASE:   lease_floor = value;
            CFG_MAX_LEASE:   lease_ceiling = value;
            CFG_MAX_PAYLOAD: payload_limit = value[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        int guard;
        while (tx_queue.size() != 0)
            @(posedge clk);
        @(posedge clk);
        while (byte_in.valid)
            @(posedge clk);
        guard = 0;
        while (expected_results.size() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        if (expected_results.size() != 0) begin
            $display("%0t: expected %0d more result beats, got none", $time,
                     expected_results.size());
            mismatches++;
            expected_results.delete();
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            payload.push_back(8'(s[i]));
    endtask

    task automatic send_payload();
        for (int i = 0; i < payload.size(); i++)
            tx_queue.push_back('{data: payload[i], last: (i == payload.size() - 1)});
        payload.delete();
    endtask

    task automatic send_text(string s);
        add_text(s);
        send_payload();
    endtask

    task automatic add_printable(int n);
        repeat (n) payload.push_back(8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI)));
    endtask

    task automatic add_number();
        int pick;
        longint unsigned near_top;
        pick = $urandom_range(9);
        if (pick < 6) begin
            repeat ($urandom_range(1, 5)) payload.push_back(8'($urandom_range(8'h30, 8'h39)));
        end else if (pick < 8) begin
            repeat ($urandom_range(6, 11)) payload.push_back(8'($urandom_range(8'h30, 8'h39)));
        end else if (pick == 8) begin
            near_top = 64'd4294967290 + 64'($urandom_range(0, 12));
            add_text($sformatf("%0d", near_top));
        end else begin
            add_text($sformatf("%0d", $urandom));
        end
    endtask

    // returns the verb table slot used, or -1 for a made-up token
    task automatic add_token(output int slot);
        int pick;
        pick = $urandom_range(7);
        slot = -1;
        if (pick < 6) begin
            add_text(verb_words[pick]);
            slot = pick;
        end else if (pick == 6) begin
            add_text(verb_words[$urandom_range(5)].substr(0, $urandom_range(0, 3)));
            add_printable($urandom_range(0, 4));
        end else begin
            add_printable($urandom_range(1, 12));
        end
    endtask

    task automatic queue_random_payload();
        int kind;
        int slot;
        kind = $urandom_range(99);
        if (kind < 65) begin
            add_token(slot);
            if ((slot >= 1 && slot <= 3) ? ($urandom_range(99) < 70) : ($urandom_range(99) < 20))
            begin
                add_text(" ");
                add_number();
            end
        end else if (kind < 85) begin
            case ($urandom_range(4))
                0: begin add_text(" "); add_token(slot); end
                1: begin add_text(verb_words[$urandom_range(1, 3)]); add_text(" "); end
                2: begin
                    add_text(verb_words[$urandom_range(1, 3)]);
                    add_text(" "); add_number(); add_text(" "); add_number();
                end
                3: begin
                    add_text(verb_words[$urandom_range(1, 3)]);
                    add_text(" "); add_number(); add_printable(1); add_number();
                end
                default: begin
                    add_text(verb_words[$urandom_range(1, 3)]);
                    add_text("  "); add_number();
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 12)) payload.push_back(8'($urandom_range(0, 255)));
        end
        send_payload();
    endtask

    initial
    begin
        logic [31:0] lo;
        byte_in.valid     = 1'b0;
        byte_in.data_byte = '0;
        byte_in.last      = 1'b0;
        result_out.ready  = 1'b0;
        cfg.valid         = 1'b0;
        cfg.index         = CFG_MIN_LEASE;
        cfg.data          = '0;
        lease_floor       = 32'd1000;
        lease_ceiling     = 32'd300000;
        payload_limit     = 16'd4096;
        clear_scan();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset configuration
        sender_idle_pct   = 24;
        receiver_idle_pct = 77;
        foreach (verb_words[i])
            send_text(verb_words[i]);
        send_text("LEASE 60000");
        send_text("HEARTBEAT 5");
        send_text("ARM 999999999");
        send_text("LEASE 4294967295");
        send_text("LEASE 4294967296");
        send_text("HEARTBEAT 9999999999");
        send_text("LEASE 0000000001");
        send_text("LEASE 00000000001");
        send_text("LEASE 000000000000000007");   // digit counter must not wrap
        send_text("LEASE ");
        send_text("LEASE 12 3");
        send_text("LEASE 5 ");
        send_text("LEASE  5");
        send_text("ARM 12a");
        send_text("STATUS 5");
        send_text("DISARM 5");
        send_text(" STATUS");
        send_text("FOO");
        send_text("STATU");
        send_text("STATUSX");
        send_text("ARMARMARMARMARMARMARM");      // token length counter saturates
        add_text("STA"); payload.push_back(8'h7F); add_text("US"); send_payload();
        payload.push_back(8'h80); add_text("ARM"); send_payload();
        wait_idle();

        // widest bounds, receiver stall, sender pause halfway
        write_reg(CFG_MIN_LEASE, 32'd0);
        write_reg(CFG_MAX_LEASE, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_PAYLOAD, 32'd65535);
        repeat (25) queue_random_payload();
        -> hold_kick;
        wait_idle();
        repeat (25) queue_random_payload();
        wait_idle();

        // inverted bounds, short payload limit
        sender_idle_pct   = 77;
        receiver_idle_pct = 24;
        write_reg(CFG_MIN_LEASE, 32'd5000);
        write_reg(CFG_MAX_LEASE, 32'd20);
        write_reg(CFG_MAX_PAYLOAD, 32'd12);
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        send_text("LEASE 123456");               // exactly at the limit
        send_text("LEASE 1234567");              // one byte over
        repeat (30) queue_random_payload();
        wait_idle();

        // payload limit of zero (upper bits masked off), then one
        write_reg(CFG_MIN_LEASE, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_LEASE, 32'd0);
        write_reg(CFG_MAX_PAYLOAD, 32'h0001_0000);
        repeat (8) queue_random_payload();
        send_text("A");
        wait_idle();
        write_reg(CFG_MAX_PAYLOAD, 32'hFFFF_0001);
        send_text("A");
        send_text("AB");
        send_text("7");
        repeat (5) queue_random_payload();
        wait_idle();

        // random bounds, no idling
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        lo = $urandom_range(0, 2000);
        write_reg(CFG_MIN_LEASE, lo);
        write_reg(CFG_MAX_LEASE, lo + $urandom_range(0, 100000));
        write_reg(CFG_MAX_PAYLOAD, 32'd65535);
        repeat (43) queue_random_payload();
        wait_idle();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> command_payload_parser.f
hdl/cpp_pkg.sv
hdl/cpp_if.sv
hdl/cpp_cfg.sv
hdl/cpp_scan.sv
hdl/cpp_result.sv
hdl/command_payload_parser.sv
tb/command_payload_parser_tb.sv
